FILE: hw/rtl/nfua_pkg.sv
package nfua_pkg;

    localparam int MAX_UNITS_DEF = 1024;

    localparam logic [15:0] UNIT_BYTES_RST   = 16'd64;
    localparam logic [10:0] ACTIVE_UNITS_RST = 11'd1024;
    localparam logic [10:0] BUSY_MAX         = 11'd2047;

    // Configuration register indexes.
    localparam logic CFG_UNIT_BYTES   = 1'b0;
    localparam logic CFG_ACTIVE_UNITS = 1'b1;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [23:0] request_bytes;
        logic [9:0]  release_unit;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [9:0]  start_unit;
        logic [10:0] units_busy;
    } t_rsp;

endpackage

FILE: hw/rtl/nfua_div.sv
module nfua_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [24:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [23:0] r_q;
    logic [15:0] r_dvs;
    logic [16:0] n_sh;
    logic        n_ge;

    assign n_sh = {r_rem, r_q[23]};
    assign n_ge = n_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= 16'(n_sh - {1'b0, r_dvs});
                end else begin
                    r_rem <= n_sh[15:0];
                end
                r_q   <= {r_q[22:0], n_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Round up: any remainder adds one unit.
    assign o_done = r_done;
    assign o_quot = {1'b0, r_q} + {24'd0, (r_rem != 16'd0)};

endmodule

FILE: hw/rtl/next_fit_unit_allocator.sv
// Next-fit allocator over a pool of fixed-size units. After reset the unit
// table is cleared one entry per cycle, and while it clears no request is
// taken (configuration writes are). An allocate first runs the bit-serial
// divider that turns bytes into units, then visits unit records in the
// search, each step being one read of the unit table followed by its
// evaluation; a free reads the released unit's record and then evaluates it.
// A result is held in an output register, so the next request may enter
// while the previous word still waits to be taken.
module next_fit_unit_allocator #(
    parameter int MAX_UNITS = nfua_pkg::MAX_UNITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nfua_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output nfua_pkg::t_rsp o_out_data
);

    localparam int AW = $clog2(MAX_UNITS);
    localparam int PW = ((AW > 11) ? AW : 11) + 2;
    localparam int EW = 12;

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_DIV       = 8'b0000_0100,
        S_RD        = 8'b0000_1000,
        S_EVAL      = 8'b0001_0000,
        S_FREE_RD   = 8'b0010_0000,
        S_FREE_EVAL = 8'b0100_0000,
        S_RESP      = 8'b1000_0000
    } t_state;

    t_state          r_state;
    logic [15:0]     r_unit_bytes;
    logic [10:0]     r_active_units;
    logic [10:0]     r_sp;
    logic [10:0]     r_busy;
    logic [AW-1:0]   r_clr;
    nfua_pkg::t_req  r_req;
    logic [10:0]     r_len;
    logic [PW-1:0]   r_i;
    logic [PW-1:0]   r_j;
    logic [PW-1:0]   r_last;
    logic            r_wrap;
    nfua_pkg::t_rsp  r_res;
    logic            r_ov;
    nfua_pkg::t_rsp  r_out;

    logic [EW-1:0]   mem [MAX_UNITS];
    logic [EW-1:0]   r_rd;

    logic            n_we;
    logic [AW-1:0]   n_wa;
    logic [EW-1:0]   n_wd;
    logic [AW-1:0]   n_ra;

    logic            n_div_start;
    logic            n_div_done;
    logic [24:0]     n_quot;
    logic [15:0]     n_divisor;

    logic [PW-1:0]   n_pool;
    logic [PW-1:0]   n_rel;
    logic            n_used;
    logic [10:0]     n_blen;
    logic [PW-1:0]   n_skip;
    logic [PW-1:0]   n_jn;
    logic [PW-1:0]   n_end;
    logic [PW-1:0]   n_spx;
    logic [11:0]     n_sum;
    logic [10:0]     n_add;
    logic [10:0]     n_sub;
    logic            n_load;

    assign n_divisor   = (r_unit_bytes == 16'd0) ? 16'd1 : r_unit_bytes;
    assign n_div_start = (r_state == S_IDLE) && i_in_valid
                         && (i_in_data.opcode == nfua_pkg::OP_ALLOC);

    nfua_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (i_in_data.request_bytes),
        .i_divisor  (n_divisor),
        .o_done     (n_div_done),
        .o_quot     (n_quot)
    );

    assign n_pool = (32'(r_active_units) < MAX_UNITS) ? PW'(r_active_units)
                                                       : PW'(MAX_UNITS);
    assign n_rel  = PW'(r_req.release_unit);
    assign n_used = r_rd[EW-1];
    assign n_blen = r_rd[10:0];
    assign n_skip = r_j + PW'(n_blen);
    assign n_jn   = r_j + PW'(1);
    assign n_end  = r_i + PW'(r_len);
    assign n_spx  = PW'(r_sp);
    assign n_sum  = {1'b0, r_busy} + {1'b0, r_len};
    assign n_add  = (n_sum > {1'b0, nfua_pkg::BUSY_MAX}) ? nfua_pkg::BUSY_MAX
                                                         : n_sum[10:0];
    assign n_sub  = (r_busy >= n_blen) ? (r_busy - n_blen) : 11'd0;
    assign n_load = (r_state == S_RESP) && (!r_ov || i_out_ready);

    assign n_ra = (r_state == S_FREE_RD) ? n_rel[AW-1:0] : r_j[AW-1:0];

    always_comb begin
        n_we = 1'b0;
        n_wa = r_i[AW-1:0];
        n_wd = {1'b1, r_len};
        case (r_state)
            S_CLEAR: begin
                n_we = 1'b1;
                n_wa = r_clr;
                n_wd = '0;
            end
            S_EVAL: begin
                n_we = !n_used && (n_jn == n_end);
            end
            S_FREE_EVAL: begin
                n_we = n_used;
                n_wa = n_rel[AW-1:0];
                n_wd = {1'b0, n_blen};
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_wa] <= n_wd;
        end
        r_rd <= mem[n_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_unit_bytes   <= nfua_pkg::UNIT_BYTES_RST;
            r_active_units <= nfua_pkg::ACTIVE_UNITS_RST;
            r_sp           <= '0;
            r_busy         <= '0;
            r_clr          <= '0;
            r_ov           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == nfua_pkg::CFG_UNIT_BYTES) begin
                    r_unit_bytes <= i_cfg_data;
                end else begin
                    r_active_units <= i_cfg_data[10:0];
                end
            end
            if (n_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAX_UNITS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        if (i_in_data.opcode == nfua_pkg::OP_ALLOC) begin
                            r_state <= S_DIV;
                        end else if (32'(i_in_data.release_unit) < MAX_UNITS) begin
                            r_state <= S_FREE_RD;
                        end else begin
                            r_res   <= '{ok: 1'b1, start_unit: '0, units_busy: r_busy};
                            r_state <= S_RESP;
                        end
                    end
                end
                S_DIV: begin
                    if (n_div_done) begin
                        if (n_quot == 25'd0 || n_quot > 25'(n_pool)) begin
                            r_res   <= '{ok: 1'b0, start_unit: '0, units_busy: r_busy};
                            r_state <= S_RESP;
                        end else begin
                            r_len  <= n_quot[10:0];
                            r_last <= n_pool - PW'(n_quot);
                            r_wrap <= 1'b0;
                            // A start past the last possible place restarts at
                            // unit zero without counting as the wrap.
                            if (n_spx > n_pool - PW'(n_quot)) begin
                                r_i <= '0;
                                r_j <= '0;
                            end else begin
                                r_i <= n_spx;
                                r_j <= n_spx;
                            end
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (n_used) begin
                        if (r_wrap && (n_skip >= n_spx || n_skip > r_last)) begin
                            r_res   <= '{ok: 1'b0, start_unit: '0, units_busy: r_busy};
                            r_state <= S_RESP;
                        end else if (n_skip > r_last) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_wrap  <= 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_i     <= n_skip;
                            r_j     <= n_skip;
                            r_state <= S_RD;
                        end
                    end else if (n_jn == n_end) begin
                        r_sp    <= n_end[10:0];
                        r_busy  <= n_add;
                        r_res   <= '{ok: 1'b1, start_unit: r_i[9:0], units_busy: n_add};
                        r_state <= S_RESP;
                    end else begin
                        r_j     <= n_jn;
                        r_state <= S_RD;
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_EVAL;
                end
                S_FREE_EVAL: begin
                    if ({1'b0, r_req.release_unit} < r_sp) begin
                        r_sp <= {1'b0, r_req.release_unit};
                    end
                    if (n_used) begin
                        r_busy <= n_sub;
                    end
                    r_res <= '{ok: 1'b1, start_unit: '0,
                               units_busy: (n_used ? n_sub : r_busy)};
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (n_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/nfua_chk.sv
module nfua_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input nfua_pkg::t_rsp o_out_data
);

    // A word waiting at the output keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // Requests are worked one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // A failed allocation reports no start unit.
    a_fail_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |-> o_out_data.start_unit == 10'd0)
        else $error("failed allocation with nonzero start unit");

    // Reset empties the output and holds off requests.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("outputs active right after reset");

endmodule

bind next_fit_unit_allocator nfua_chk u_nfua_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: dv/nfua_checker.sv
`timescale 1ns / 100ps

module nfua_checker #(
    parameter int MAX_UNITS = nfua_pkg::MAX_UNITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  nfua_pkg::t_req i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  nfua_pkg::t_rsp i_out_data,
    output int             o_errors,
    output int             o_pending
);

    logic [15:0]    unit_bytes_r;
    logic [10:0]    active_units_r;
    bit             head_used [MAX_UNITS];
    logic [10:0]    block_len [MAX_UNITS];
    int             search_ptr;
    int             busy_units;
    nfua_pkg::t_rsp pending_rsp [$];

    // Next-fit walk from the roving pointer; one wrap to unit 0 is allowed.
    function automatic bit next_fit_search(input int pool, input int len, output int where);
        int  last;
        int  i;
        bit  wrapped;
        bit  clear;
        last    = pool - len;
        i       = search_ptr;
        wrapped = 0;
        where   = 0;
        if (i > last) i = 0;
        forever begin
            if (head_used[i]) begin
                i += block_len[i];
            end else begin
                clear = 1;
                for (int j = i; j < i + len; j++) begin
                    if (head_used[j]) begin
                        i = j + block_len[j];
                        clear = 0;
                        break;
                    end
                end
                if (clear) begin
                    where = i;
                    return 1;
                end
            end
            if (wrapped && (i >= search_ptr || i > last)) return 0;
            if (i > last) begin
                i = 0;
                wrapped = 1;
            end
        end
    endfunction

    function automatic nfua_pkg::t_rsp predict_word(input nfua_pkg::t_req req);
        nfua_pkg::t_rsp rsp;
        int   ub;
        int   pool;
        int   len;
        int   at;
        rsp = '0;
        if (req.opcode == nfua_pkg::OP_ALLOC) begin
            ub   = (unit_bytes_r == 0) ? 1 : int'(unit_bytes_r);
            pool = (int'(active_units_r) < MAX_UNITS) ? int'(active_units_r) : MAX_UNITS;
            len  = (int'(req.request_bytes) + ub - 1) / ub;
            if (len != 0 && len <= pool && next_fit_search(pool, len, at)) begin
                head_used[at] = 1;
                block_len[at] = len[10:0];
                search_ptr    = at + len;
                busy_units    = busy_units + len;
                if (busy_units > 2047) busy_units = 2047;
                rsp.ok         = 1'b1;
                rsp.start_unit = at[9:0];
            end
        end else begin
            rsp.ok = 1'b1;
            if (int'(req.release_unit) < MAX_UNITS) begin
                if (int'(req.release_unit) < search_ptr) search_ptr = req.release_unit;
                if (head_used[req.release_unit]) begin
                    head_used[req.release_unit] = 0;
                    busy_units = busy_units - block_len[req.release_unit];
                    if (busy_units < 0) busy_units = 0;
                end
            end
        end
        rsp.units_busy = busy_units[10:0];
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        nfua_pkg::t_rsp want;
        if (!i_rst_n) begin
            unit_bytes_r   <= nfua_pkg::UNIT_BYTES_RST;
            active_units_r <= nfua_pkg::ACTIVE_UNITS_RST;
            for (int k = 0; k < MAX_UNITS; k++) begin
                head_used[k] = 0;
                block_len[k] = '0;
            end
            search_ptr = 0;
            busy_units = 0;
            pending_rsp.delete();
            o_errors  <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == nfua_pkg::CFG_UNIT_BYTES) unit_bytes_r <= i_cfg_data;
                else active_units_r <= i_cfg_data[10:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_rsp.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected output word %p", $realtime, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_rsp.pop_front();
                    if (want.ok !== i_out_data.ok || want.start_unit !== i_out_data.start_unit
                        || want.units_busy !== i_out_data.units_busy) begin
                        if (o_errors < 10)
                            $display({"%0t: mismatch: expected ok=%0d start=%0d busy=%0d,",
                                      " got ok=%0d start=%0d busy=%0d"},
                                     $realtime, want.ok, want.start_unit, want.units_busy,
                                     i_out_data.ok, i_out_data.start_unit,
                                     i_out_data.units_busy);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) pending_rsp.push_back(predict_word(i_in_data));
        end
        o_pending <= pending_rsp.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT = 20000;

    logic   i_clk = 0;
    logic   i_rst_n = 0;
    logic   i_cfg_we = 0;
    logic   i_cfg_idx = nfua_pkg::CFG_UNIT_BYTES;
    logic [15:0] i_cfg_data = '0;
    logic   i_in_valid = 0;
    logic   o_in_ready;
    nfua_pkg::t_req i_in_data = '0;
    logic   o_out_valid;
    logic   i_out_ready = 0;
    nfua_pkg::t_rsp o_out_data;
    int     errors;
    int     pending;
    int     cur_ub = 64;
    bit     no_idle = 0;
    int     granted_heads [$];
    int     idle_cycles = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    next_fit_unit_allocator i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data
    );

    nfua_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: random stall before each word unless no_idle, heads of granted blocks are kept for frees.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1;
            do @(posedge i_clk); while (!o_out_valid);
            if (o_out_data.ok) granted_heads.push_back(int'(o_out_data.start_unit));
        end
    end

    task automatic write_cfg(input logic idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        if (idx == nfua_pkg::CFG_UNIT_BYTES) cur_ub = (value == 0) ? 1 : int'(value);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic send_word(input nfua_pkg::t_req req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = req;
        i_in_valid = 1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_in_valid = 0;
    endtask

    task automatic send_alloc(input int bytes);
        nfua_pkg::t_req req;
        req = '0;
        req.opcode        = nfua_pkg::OP_ALLOC;
        req.request_bytes = bytes[23:0];
        req.release_unit  = 10'($urandom());
        send_word(req);
    endtask

    task automatic send_free(input int unit_idx);
        nfua_pkg::t_req req;
        req = '0;
        req.opcode        = nfua_pkg::OP_FREE;
        req.request_bytes = 24'($urandom());
        req.release_unit  = unit_idx[9:0];
        send_word(req);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_items(input int count);
        int r;
        int k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) send_alloc($urandom_range(1, cur_ub * 6));
            else if (r < 60) send_alloc($urandom_range(0, 24'hFFFFFF));
            else if (r < 62) send_alloc(0);
            else if (r < 90 && granted_heads.size() > 0) begin
                k = $urandom_range(0, granted_heads.size() - 1);
                send_free(granted_heads[k]);
                granted_heads.delete(k);
            end else send_free($urandom_range(0, 1023));
            if (n == count / 2 && count > 50) begin
                // Let the block drain completely before carrying on.
                drop_valid();
                while (pending != 0) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;

        // Directed words at the reset configuration.
        send_alloc(0);
        send_alloc(24'hFFFFFF);
        send_alloc(1);
        send_alloc(64);
        send_alloc(65);
        send_alloc(64 * 1024);
        send_free(1023);
        send_free(0);
        send_free(0);
        send_alloc(100);
        send_free(700);
        send_alloc(64 * 1000);
        send_alloc(64 * 30);
        send_free(1);
        send_alloc(64 * 5);
        send_alloc(64 * 24);
        wait_drained();
        random_items(100);
        wait_drained();

        write_cfg(nfua_pkg::CFG_UNIT_BYTES, 16'd1);
        no_idle = 1;
        random_items(100);
        wait_drained();
        no_idle = 0;

        write_cfg(nfua_pkg::CFG_UNIT_BYTES, 16'd0);
        write_cfg(nfua_pkg::CFG_ACTIVE_UNITS, 16'd1000);
        random_items(100);
        wait_drained();

        write_cfg(nfua_pkg::CFG_UNIT_BYTES, 16'hFFFF);
        write_cfg(nfua_pkg::CFG_ACTIVE_UNITS, 16'd1);
        send_alloc(65535);
        send_alloc(65536);
        random_items(80);
        wait_drained();

        write_cfg(nfua_pkg::CFG_UNIT_BYTES, 16'd7);
        write_cfg(nfua_pkg::CFG_ACTIVE_UNITS, 16'd37);
        random_items(100);
        wait_drained();

        write_cfg(nfua_pkg::CFG_UNIT_BYTES, 16'd100);
        write_cfg(nfua_pkg::CFG_ACTIVE_UNITS, 16'd2047);
        random_items(100);
        wait_drained();

        write_cfg(nfua_pkg::CFG_UNIT_BYTES, 16'd3);
        write_cfg(nfua_pkg::CFG_ACTIVE_UNITS, 16'd16);
        random_items(100);
        wait_drained();

        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/nfua_pkg.sv
hw/rtl/nfua_div.sv
hw/rtl/next_fit_unit_allocator.sv
hw/rtl/nfua_chk.sv
dv/nfua_checker.sv
dv/tb.sv
